FILE: hw/rtl/pwdr_pkg.sv
`default_nettype none

package pwdr_pkg;

    // field widths
    localparam int DIM_W      = 12;
    localparam int PITCH_W    = 14;
    localparam int BPP_W      = 3;
    localparam int COLOR_W    = 32;
    localparam int OFFSET_W   = 24;
    localparam int BE_W       = 4;
    localparam int MODE_W     = 2;
    localparam int GLYPH_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;

    // glyph expansion
    localparam int GLYPH_WIDTH = 8;
    localparam int COL_W       = $clog2(GLYPH_WIDTH);
    localparam int CNT_W       = COL_W + 1;

    // default screen limits
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // register reset values
    localparam logic [DIM_W-1:0]   SCREEN_WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0]   SCREEN_HEIGHT_RST = 12'd480;
    localparam logic [PITCH_W-1:0] ROW_PITCH_RST     = 14'd2560;
    localparam logic [BPP_W-1:0]   BPP_RST           = 3'd4;

    // pixel formats
    localparam logic [BPP_W-1:0]   BPP_NARROW     = 3'd3;
    localparam logic [BE_W-1:0]    BE_NARROW      = 4'h7;
    localparam logic [BE_W-1:0]    BE_WIDE        = 4'hF;
    localparam logic [COLOR_W-1:0] COLOR_LOW_MASK = 32'h00FF_FFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_PIXEL = 2'd0,
        MODE_GLYPH = 2'd1,
        MODE_FLUSH = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH    = 2'd0,
        REG_SCREEN_HEIGHT   = 2'd1,
        REG_ROW_PITCH       = 2'd2,
        REG_BYTES_PER_PIXEL = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic                write_valid;
        logic [OFFSET_W-1:0] byte_offset;
        logic [COLOR_W-1:0]  write_data;
        logic [BE_W-1:0]     byte_enable;
        logic                rect_valid;
        logic [DIM_W-1:0]    rect_x_min;
        logic [DIM_W-1:0]    rect_x_max;
        logic [DIM_W-1:0]    rect_y_min;
        logic [DIM_W-1:0]    rect_y_max;
        logic                last_result;
    } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pwdr_out_skid.sv
`default_nettype none

module pwdr_out_skid (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire pwdr_pkg::result_t in_res,
    output logic               out_valid,
    input  wire                out_ready,
    output pwdr_pkg::result_t  out_res
);
    import pwdr_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_res_reg, main_res_next;
    result_t skid_res_reg, skid_res_next;
    logic    push;

    // upstream only sees the skid slot, so ready never depends on out_ready
    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_res   = main_res_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_res_next   = main_res_reg;
        skid_res_next   = skid_res_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_res_next   = skid_res_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
                main_res_next   = in_res;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_res_reg <= main_res_next;
        skid_res_reg <= skid_res_next;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pixel_writer_dirty_rect_core.sv
// Pixel writer with dirty-rectangle tracking. Each request is a put-pixel, a
// glyph row or a flush. A put-pixel on screen gives one byte write at
// y*row_pitch + x*pixel_size (wrapping at 24 bits) with a 3- or 4-lane mask;
// a glyph row gives one write per visible glyph bit, most significant bit at
// the leftmost column, clipped at the right edge; a flush gives the dirty box
// (right and bottom clamped to the current screen) and clears it. Every write
// grows the box. Requests that are off screen, and the unused mode code,
// produce no result and leave the box alone. Rate: a request is registered on
// acceptance (the row multiply happens there), then the expansion stage
// issues one result per cycle while the output buffer has room; a put-pixel
// or flush gives one result, a glyph row one per written pixel (1 to 8), and
// a request with no result gives none; the next request is accepted in the
// cycle the previous one issues its final result. A two-entry output buffer
// decouples the expansion stage from m_ready: its ready comes from a register,
// not from m_ready. Configuration is to be written only while the block is
// idle; the block itself does not enforce it.
`default_nettype none

module pixel_writer_dirty_rect_core #(
    parameter int MAX_WIDTH  = pwdr_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = pwdr_pkg::MAX_HEIGHT_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // configuration write port
    input  wire                                 cfg_wr_en,
    input  wire  [pwdr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [pwdr_pkg::CFG_DATA_W-1:0]     cfg_data,
    // request channel
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire  [pwdr_pkg::MODE_W-1:0]         s_mode,
    input  wire  [pwdr_pkg::DIM_W-1:0]          s_pos_x,
    input  wire  [pwdr_pkg::DIM_W-1:0]          s_pos_y,
    input  wire  [pwdr_pkg::COLOR_W-1:0]        s_fore_color,
    input  wire  [pwdr_pkg::COLOR_W-1:0]        s_back_color,
    input  wire  [pwdr_pkg::GLYPH_W-1:0]        s_glyph_bits,
    // result channel
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic                                m_write_valid,
    output logic [pwdr_pkg::OFFSET_W-1:0]       m_byte_offset,
    output logic [pwdr_pkg::COLOR_W-1:0]        m_write_data,
    output logic [pwdr_pkg::BE_W-1:0]           m_byte_enable,
    output logic                                m_rect_valid,
    output logic [pwdr_pkg::DIM_W-1:0]          m_rect_x_min,
    output logic [pwdr_pkg::DIM_W-1:0]          m_rect_x_max,
    output logic [pwdr_pkg::DIM_W-1:0]          m_rect_y_min,
    output logic [pwdr_pkg::DIM_W-1:0]          m_rect_y_max,
    output logic                                m_last_result
);
    import pwdr_pkg::*;

    // screen limits in one extra bit so a limit of 4096 still compares right
    localparam logic [DIM_W:0] MAX_W_EXT = (DIM_W + 1)'(MAX_WIDTH);
    localparam logic [DIM_W:0] MAX_H_EXT = (DIM_W + 1)'(MAX_HEIGHT);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   screen_width_reg;
    logic [DIM_W-1:0]   screen_height_reg;
    logic [PITCH_W-1:0] row_pitch_reg;
    logic [BPP_W-1:0]   bpp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
            row_pitch_reg     <= ROW_PITCH_RST;
            bpp_reg           <= BPP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_SCREEN_WIDTH:    screen_width_reg  <= cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT:   screen_height_reg <= cfg_data[DIM_W-1:0];
                REG_ROW_PITCH:       row_pitch_reg     <= cfg_data[PITCH_W-1:0];
                REG_BYTES_PER_PIXEL: bpp_reg           <= cfg_data[BPP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // effective screen size, oversized settings clamp to the limits
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic             wide_px;

    assign w_eff   = ({1'b0, screen_width_reg} > MAX_W_EXT) ? MAX_W_EXT[DIM_W-1:0]
                                                            : screen_width_reg;
    assign h_eff   = ({1'b0, screen_height_reg} > MAX_H_EXT) ? MAX_H_EXT[DIM_W-1:0]
                                                             : screen_height_reg;
    // anything but 3 bytes per pixel means 32-bit pixels
    assign wide_px = (bpp_reg != BPP_NARROW);

    // ------------------------------------------------------------------
    // request decode at acceptance
    // ------------------------------------------------------------------
    mode_t                   s_mode_c;
    logic                    on_screen;
    logic [DIM_W-1:0]        span;
    logic [CNT_W-1:0]        glyph_cnt;
    logic [CNT_W-1:0]        count_c;
    logic [DIM_W-1:0]        end_c;
    logic                    has_res_c;
    logic [DIM_W+PITCH_W-1:0] row_prod;

    assign s_mode_c  = mode_t'(s_mode);
    assign on_screen = (s_pos_x < w_eff) && (s_pos_y < h_eff);
    assign span      = w_eff - s_pos_x;
    // pixels of a glyph row left of the right edge
    assign glyph_cnt = (span >= DIM_W'(GLYPH_WIDTH)) ? CNT_W'(GLYPH_WIDTH)
                                                      : span[CNT_W-1:0];
    assign count_c   = (s_mode_c == MODE_GLYPH) ? glyph_cnt : CNT_W'(1);
    assign end_c     = s_pos_x + DIM_W'(count_c);
    assign row_prod  = s_pos_y * row_pitch_reg;

    always_comb begin
        case (s_mode_c)
            MODE_PIXEL: has_res_c = on_screen;
            MODE_GLYPH: has_res_c = on_screen;
            MODE_FLUSH: has_res_c = 1'b1;
            default:    has_res_c = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // expansion stage: while the output buffer has room, one result per cycle
    // ------------------------------------------------------------------
    logic                work_valid_reg, work_valid_next;
    mode_t               work_mode_reg;
    logic                work_has_res_reg;
    logic [DIM_W-1:0]    work_x_reg;
    logic [DIM_W-1:0]    work_y_reg;
    logic [COLOR_W-1:0]  work_fg_reg;
    logic [COLOR_W-1:0]  work_bg_reg;
    logic [GLYPH_W-1:0]  work_bits_reg, work_bits_next;
    logic [COL_W-1:0]    work_col_reg, work_col_next;
    logic [CNT_W-1:0]    work_cnt_reg;
    logic [DIM_W-1:0]    work_end_reg;
    logic [OFFSET_W-1:0] work_row_base_reg;

    logic s_accept;
    logic out_ready_int;
    logic step;
    logic last_col;
    logic finishing;

    assign last_col  = ({1'b0, work_col_reg} + CNT_W'(1)) == work_cnt_reg;
    // a request with no result retires without waiting for the output buffer
    assign step      = work_valid_reg && (!work_has_res_reg || out_ready_int);
    assign finishing = step && (!work_has_res_reg || last_col);
    assign s_ready   = !work_valid_reg || finishing;
    assign s_accept  = s_valid && s_ready;

    always_comb begin
        work_valid_next = work_valid_reg;
        work_bits_next  = work_bits_reg;
        work_col_next   = work_col_reg;
        if (s_accept) begin
            work_valid_next = 1'b1;
            work_bits_next  = s_glyph_bits;
            work_col_next   = '0;
        end else if (finishing) begin
            work_valid_next = 1'b0;
        end else if (step) begin
            // next glyph column: shift the leftmost bit out
            work_bits_next = {work_bits_reg[GLYPH_W-2:0], 1'b0};
            work_col_next  = work_col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
        end else begin
            work_valid_reg <= work_valid_next;
        end
        work_bits_reg <= work_bits_next;
        work_col_reg  <= work_col_next;
        if (s_accept) begin
            work_mode_reg     <= s_mode_c;
            work_has_res_reg  <= has_res_c;
            work_x_reg        <= s_pos_x;
            work_y_reg        <= s_pos_y;
            work_fg_reg       <= s_fore_color;
            work_bg_reg       <= s_back_color;
            work_cnt_reg      <= count_c;
            work_end_reg      <= end_c;
            work_row_base_reg <= row_prod[OFFSET_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // dirty box
    // ------------------------------------------------------------------
    logic             dirty_flag_reg, dirty_flag_next;
    logic [DIM_W-1:0] dirty_left_reg, dirty_left_next;
    logic [DIM_W-1:0] dirty_right_reg, dirty_right_next;
    logic [DIM_W-1:0] dirty_top_reg, dirty_top_next;
    logic [DIM_W-1:0] dirty_bottom_reg, dirty_bottom_next;
    logic [DIM_W-1:0] row_end;

    assign row_end = work_y_reg + DIM_W'(1);

    // the box is updated when a request retires, so a flush behind it sees it
    always_comb begin
        dirty_flag_next   = dirty_flag_reg;
        dirty_left_next   = dirty_left_reg;
        dirty_right_next  = dirty_right_reg;
        dirty_top_next    = dirty_top_reg;
        dirty_bottom_next = dirty_bottom_reg;
        if (finishing && work_has_res_reg) begin
            case (work_mode_reg)
                MODE_PIXEL, MODE_GLYPH: begin
                    dirty_flag_next = 1'b1;
                    if (!dirty_flag_reg) begin
                        dirty_left_next   = work_x_reg;
                        dirty_right_next  = work_end_reg;
                        dirty_top_next    = work_y_reg;
                        dirty_bottom_next = row_end;
                    end else begin
                        if (work_x_reg < dirty_left_reg) begin
                            dirty_left_next = work_x_reg;
                        end
                        if (work_end_reg > dirty_right_reg) begin
                            dirty_right_next = work_end_reg;
                        end
                        if (work_y_reg < dirty_top_reg) begin
                            dirty_top_next = work_y_reg;
                        end
                        if (row_end > dirty_bottom_reg) begin
                            dirty_bottom_next = row_end;
                        end
                    end
                end
                MODE_FLUSH: begin
                    dirty_flag_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_flag_reg   <= 1'b0;
            dirty_left_reg   <= '0;
            dirty_right_reg  <= '0;
            dirty_top_reg    <= '0;
            dirty_bottom_reg <= '0;
        end else begin
            dirty_flag_reg   <= dirty_flag_next;
            dirty_left_reg   <= dirty_left_next;
            dirty_right_reg  <= dirty_right_next;
            dirty_top_reg    <= dirty_top_next;
            dirty_bottom_reg <= dirty_bottom_next;
        end
    end

    // ------------------------------------------------------------------
    // result formation
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]    px;
    logic [OFFSET_W-1:0] px_ext;
    logic [OFFSET_W-1:0] px_bytes;
    logic [COLOR_W-1:0]  px_color;
    logic [DIM_W-1:0]    clamp_right;
    logic [DIM_W-1:0]    clamp_bottom;
    result_t             work_res;

    assign px       = work_x_reg + DIM_W'(work_col_reg);
    assign px_ext   = OFFSET_W'(px);
    // x*4 for 32-bit pixels, x*3 for 24-bit pixels
    assign px_bytes = wide_px ? (px_ext << 2) : ((px_ext << 1) + px_ext);
    // glyph bits pick foreground or background, a plain pixel is foreground
    assign px_color = ((work_mode_reg == MODE_GLYPH) && !work_bits_reg[GLYPH_W-1])
                      ? work_bg_reg : work_fg_reg;
    // flush clamps only the right and bottom edges to the current screen
    assign clamp_right  = (dirty_right_reg > w_eff) ? w_eff : dirty_right_reg;
    assign clamp_bottom = (dirty_bottom_reg > h_eff) ? h_eff : dirty_bottom_reg;

    always_comb begin
        work_res = '0;
        case (work_mode_reg)
            MODE_PIXEL, MODE_GLYPH: begin
                work_res.write_valid = 1'b1;
                work_res.byte_offset = work_row_base_reg + px_bytes;
                work_res.write_data  = wide_px ? px_color : (px_color & COLOR_LOW_MASK);
                work_res.byte_enable = wide_px ? BE_WIDE : BE_NARROW;
                work_res.last_result = last_col;
            end
            MODE_FLUSH: begin
                // a clean flush reports an all-zero box
                work_res.rect_valid  = dirty_flag_reg;
                if (dirty_flag_reg) begin
                    work_res.rect_x_min = dirty_left_reg;
                    work_res.rect_x_max = clamp_right;
                    work_res.rect_y_min = dirty_top_reg;
                    work_res.rect_y_max = clamp_bottom;
                end
                work_res.last_result = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // output buffer
    // ------------------------------------------------------------------
    result_t out_res;

    pwdr_out_skid u_out_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (work_valid_reg && work_has_res_reg),
        .in_ready  (out_ready_int),
        .in_res    (work_res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_write_valid = out_res.write_valid;
    assign m_byte_offset = out_res.byte_offset;
    assign m_write_data  = out_res.write_data;
    assign m_byte_enable = out_res.byte_enable;
    assign m_rect_valid  = out_res.rect_valid;
    assign m_rect_x_min  = out_res.rect_x_min;
    assign m_rect_x_max  = out_res.rect_x_max;
    assign m_rect_y_min  = out_res.rect_y_min;
    assign m_rect_y_max  = out_res.rect_y_max;
    assign m_last_result = out_res.last_result;

`ifndef SYNTHESIS
    // a retiring flush always leaves the box clean
    assert property (@(posedge aclk) disable iff (!aresetn)
        (finishing && work_has_res_reg && (work_mode_reg == MODE_FLUSH))
        |=> !dirty_flag_reg)
    else $error("dirty box not cleared after flush");

    // a retiring on-screen write always leaves the box marked
    assert property (@(posedge aclk) disable iff (!aresetn)
        (finishing && work_has_res_reg &&
         ((work_mode_reg == MODE_PIXEL) || (work_mode_reg == MODE_GLYPH)))
        |=> dirty_flag_reg)
    else $error("dirty box not marked after write");

    // the column counter never runs past the visible glyph pixels
    assert property (@(posedge aclk) disable iff (!aresetn)
        (work_valid_reg && work_has_res_reg)
        |-> (({1'b0, work_col_reg} < work_cnt_reg) && (work_cnt_reg != '0)))
    else $error("glyph column beyond visible count");

    // a write result never carries a rectangle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_write_valid) |-> (!m_rect_valid && (m_byte_enable != '0)))
    else $error("write result with rectangle fields");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pwdr_pkg::*;

    // mode code that the block must ignore
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // cycles to let an ignored request finish before touching the registers
    localparam int SETTLE_CYCLES = 16;
    // watchdog: cycles without any handshake before the run is declared hung
    localparam int HANG_LIMIT    = 3000;
    // long receiver hold-off so the output buffer fills and s_ready drops
    localparam int LONG_HOLD     = 400;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_REQS    = 46;
    localparam int HOLD_PHASE    = 4;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [DIM_W-1:0]   pos_x;
        logic [DIM_W-1:0]   pos_y;
        logic [COLOR_W-1:0] fore_color;
        logic [COLOR_W-1:0] back_color;
        logic [GLYPH_W-1:0] glyph_bits;
    } draw_cmd_t;

    // clock, reset and every block input start at a known value
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid      = 1'b0;
    logic [MODE_W-1:0]     s_mode       = '0;
    logic [DIM_W-1:0]      s_pos_x      = '0;
    logic [DIM_W-1:0]      s_pos_y      = '0;
    logic [COLOR_W-1:0]    s_fore_color = '0;
    logic [COLOR_W-1:0]    s_back_color = '0;
    logic [GLYPH_W-1:0]    s_glyph_bits = '0;
    logic                  m_ready      = 1'b0;

    logic                  s_ready;
    logic                  m_valid;
    logic                  m_write_valid;
    logic [OFFSET_W-1:0]   m_byte_offset;
    logic [COLOR_W-1:0]    m_write_data;
    logic [BE_W-1:0]       m_byte_enable;
    logic                  m_rect_valid;
    logic [DIM_W-1:0]      m_rect_x_min;
    logic [DIM_W-1:0]      m_rect_x_max;
    logic [DIM_W-1:0]      m_rect_y_min;
    logic [DIM_W-1:0]      m_rect_y_max;
    logic                  m_last_result;

    pixel_writer_dirty_rect_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_pos_x       (s_pos_x),
        .s_pos_y       (s_pos_y),
        .s_fore_color  (s_fore_color),
        .s_back_color  (s_back_color),
        .s_glyph_bits  (s_glyph_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_valid (m_write_valid),
        .m_byte_offset (m_byte_offset),
        .m_write_data  (m_write_data),
        .m_byte_enable (m_byte_enable),
        .m_rect_valid  (m_rect_valid),
        .m_rect_x_min  (m_rect_x_min),
        .m_rect_x_max  (m_rect_x_max),
        .m_rect_y_min  (m_rect_y_min),
        .m_rect_y_max  (m_rect_y_max),
        .m_last_result (m_last_result)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor: own copy of the registers and of the dirty box
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   scr_width   = SCREEN_WIDTH_RST;
    logic [DIM_W-1:0]   scr_height  = SCREEN_HEIGHT_RST;
    logic [PITCH_W-1:0] pitch_bytes = ROW_PITCH_RST;
    logic [BPP_W-1:0]   pixel_bytes = BPP_RST;

    bit          box_dirty  = 1'b0;
    int unsigned box_left   = 0;
    int unsigned box_right  = 0;
    int unsigned box_top    = 0;
    int unsigned box_bottom = 0;

    draw_cmd_t draw_cmds[$];      // requests waiting for the driver
    result_t   write_rect_q[$];   // predicted pixel writes and rect reports, oldest first

    int err_count   = 0;
    int n_reqs      = 0;
    int n_writes    = 0;
    int n_flushes   = 0;
    int n_checked   = 0;
    int n_settings  = 1;

    // visible size after clamping to the synthesized maximum
    function automatic int unsigned vis_width();
        return (scr_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : scr_width;
    endfunction

    function automatic int unsigned vis_height();
        return (scr_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : scr_height;
    endfunction

    function automatic result_t make_write(input int unsigned x, input int unsigned y,
                                           input logic [COLOR_W-1:0] color, input bit last);
        result_t     r;
        bit          wide;
        int unsigned sz;
        logic [31:0] off;
        wide = (pixel_bytes != BPP_NARROW);
        sz   = wide ? 4 : 3;
        off  = y * pitch_bytes + x * sz;
        r    = '0;
        r.write_valid = 1'b1;
        r.byte_offset = off[OFFSET_W-1:0];
        r.write_data  = wide ? color : (color & COLOR_LOW_MASK);
        r.byte_enable = wide ? BE_WIDE : BE_NARROW;
        r.last_result = last;
        return r;
    endfunction

    task automatic grow_box(input int unsigned l, input int unsigned r,
                            input int unsigned t, input int unsigned b);
        if (!box_dirty) begin
            box_left   = l;
            box_right  = r;
            box_top    = t;
            box_bottom = b;
            box_dirty  = 1'b1;
        end else begin
            if (l < box_left)   box_left   = l;
            if (r > box_right)  box_right  = r;
            if (t < box_top)    box_top    = t;
            if (b > box_bottom) box_bottom = b;
        end
    endtask

    // expected results of one accepted request, and the box update it causes
    task automatic draw_and_track(input draw_cmd_t c);
        int unsigned w, h, x, y, span_end, px;
        result_t     r;
        w = vis_width();
        h = vis_height();
        x = c.pos_x;
        y = c.pos_y;
        case (c.mode)
            MODE_PIXEL: begin
                if (x < w && y < h) begin
                    write_rect_q.push_back(make_write(x, y, c.fore_color, 1'b1));
                    n_writes++;
                    grow_box(x, x + 1, y, y + 1);
                end
            end
            MODE_GLYPH: begin
                // rows below the screen or starting right of it mark nothing
                if (x < w && y < h) begin
                    span_end = x + GLYPH_WIDTH;
                    if (span_end > w) span_end = w;
                    for (int col = 0; col < GLYPH_WIDTH; col++) begin
                        px = x + col;
                        if (px < span_end) begin
                            write_rect_q.push_back(make_write(px, y,
                                c.glyph_bits[GLYPH_WIDTH-1-col] ? c.fore_color : c.back_color,
                                px + 1 == span_end));
                            n_writes++;
                        end
                    end
                    grow_box(x, span_end, y, y + 1);
                end
            end
            MODE_FLUSH: begin
                // only right and bottom are clamped, so min may pass max after a shrink
                r = '0;
                r.rect_valid  = box_dirty;
                r.last_result = 1'b1;
                if (box_dirty) begin
                    r.rect_x_min = DIM_W'(box_left);
                    r.rect_y_min = DIM_W'(box_top);
                    r.rect_x_max = DIM_W'((box_right > w) ? w : box_right);
                    r.rect_y_max = DIM_W'((box_bottom > h) ? h : box_bottom);
                end
                write_rect_q.push_back(r);
                n_flushes++;
                box_dirty = 1'b0;
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of random length with random gaps in between
    // ------------------------------------------------------------------
    draw_cmd_t cur_cmd;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                draw_and_track(cur_cmd);
                n_reqs++;
            end
            // payload only moves once the previous request has gone
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (draw_cmds.size() > 0) begin
                    cur_cmd      = draw_cmds.pop_front();
                    s_mode       <= cur_cmd.mode;
                    s_pos_x      <= cur_cmd.pos_x;
                    s_pos_y      <= cur_cmd.pos_y;
                    s_fore_color <= cur_cmd.fore_color;
                    s_back_color <= cur_cmd.back_color;
                    s_glyph_bits <= cur_cmd.glyph_bits;
                    s_valid      <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // new burst; a quarter of them follow on with no gap
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result and stalls on its own pattern
    // ------------------------------------------------------------------
    result_t want;
    int      rx_tick        = 0;
    int      rx_style       = 0;
    int      hold_cnt       = 0;
    bit      long_hold_req  = 1'b0;  // raised once by the stimulus
    bit      long_hold_done = 1'b0;

    task automatic cmp_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (write_rect_q.size() == 0) begin
                    $error("result with nothing expected: write_valid %0b rect_valid %0b",
                           m_write_valid, m_rect_valid);
                    err_count++;
                end else begin
                    want = write_rect_q.pop_front();
                    n_checked++;
                    cmp_field("write_valid", want.write_valid, m_write_valid);
                    cmp_field("byte_offset", want.byte_offset, m_byte_offset);
                    cmp_field("write_data",  want.write_data,  m_write_data);
                    cmp_field("byte_enable", want.byte_enable, m_byte_enable);
                    cmp_field("rect_valid",  want.rect_valid,  m_rect_valid);
                    cmp_field("rect_x_min",  want.rect_x_min,  m_rect_x_min);
                    cmp_field("rect_x_max",  want.rect_x_max,  m_rect_x_max);
                    cmp_field("rect_y_min",  want.rect_y_min,  m_rect_y_min);
                    cmp_field("rect_y_max",  want.rect_y_max,  m_rect_y_max);
                    cmp_field("last_result", want.last_result, m_last_result);
                end
            end
            rx_tick++;
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 1'b0;
            end else if (long_hold_req && !long_hold_done) begin
                // sender keeps offering while we hold, so the block backs up
                long_hold_done = 1'b1;
                hold_cnt       = LONG_HOLD;
                m_ready        <= 1'b0;
            end else begin
                if (rx_tick % 97 == 0) rx_style = $urandom_range(0, 3);
                case (rx_style)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (rx_tick % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    // watchdog: any handshake resets the count
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= HANG_LIMIT) begin
                $error("no handshake for %0d cycles, %0d results still due",
                       idle_cycles, write_rect_q.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic draw_cmd_t cmd(input logic [MODE_W-1:0] mode,
                                      input int unsigned x, input int unsigned y,
                                      input logic [COLOR_W-1:0] fg,
                                      input logic [COLOR_W-1:0] bg,
                                      input logic [GLYPH_W-1:0] glyph);
        draw_cmd_t c;
        c.mode       = mode;
        c.pos_x      = DIM_W'(x);
        c.pos_y      = DIM_W'(y);
        c.fore_color = fg;
        c.back_color = bg;
        c.glyph_bits = glyph;
        return c;
    endfunction

    function automatic logic [COLOR_W-1:0] rand_color();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom();
        endcase
    endfunction

    // mostly on screen, edges favored, some off screen
    function automatic logic [DIM_W-1:0] pick_coord(input int unsigned lim);
        if (lim == 0 || $urandom_range(0, 9) == 0)
            return DIM_W'($urandom_range(lim, 4095));
        if ($urandom_range(0, 4) == 0)
            return DIM_W'($urandom_range(0, 1) ? lim - 1 : 0);
        return DIM_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic draw_cmd_t rand_cmd();
        draw_cmd_t   c;
        int unsigned w, h, pick;
        w    = vis_width();
        h    = vis_height();
        pick = $urandom_range(0, 99);
        c.fore_color = rand_color();
        c.back_color = rand_color();
        c.glyph_bits = GLYPH_W'($urandom_range(0, 255));
        c.pos_x      = pick_coord(w);
        c.pos_y      = pick_coord(h);
        if (pick < 5) begin
            // noise over the whole field range
            c.mode  = MODE_W'($urandom_range(0, 3));
            c.pos_x = DIM_W'($urandom());
            c.pos_y = DIM_W'($urandom());
        end else if (pick < 40) begin
            c.mode = MODE_PIXEL;
        end else if (pick < 80) begin
            c.mode = MODE_GLYPH;
            // rows that hit the right edge
            if (w > 0 && $urandom_range(0, 9) < 3)
                c.pos_x = DIM_W'($urandom_range((w > GLYPH_WIDTH) ? w - GLYPH_WIDTH : 0,
                                                w - 1));
        end else if (pick < 95) begin
            c.mode = MODE_FLUSH;
        end else begin
            c.mode = MODE_UNUSED;
        end
        return c;
    endfunction

    function automatic int unsigned rand_dim();
        return $urandom_range(0, 1) ? $urandom_range(1, 64) : $urandom_range(1, 4095);
    endfunction

    // every request accepted, every result back, then room for ignored ones
    task automatic wait_idle();
        do @(negedge aclk);
        while (draw_cmds.size() != 0 || s_valid || write_rect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_SCREEN_WIDTH:    scr_width   = data[DIM_W-1:0];
            REG_SCREEN_HEIGHT:   scr_height  = data[DIM_W-1:0];
            REG_ROW_PITCH:       pitch_bytes = data[PITCH_W-1:0];
            REG_BYTES_PER_PIXEL: pixel_bytes = data[BPP_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // unused upper data bits carry junk that the block must drop
    task automatic set_screen(input int unsigned w, input int unsigned h,
                              input int unsigned pitch, input int unsigned bpp);
        write_reg(REG_SCREEN_WIDTH,    CFG_DATA_W'(($urandom() << DIM_W) | (w & 12'hFFF)));
        write_reg(REG_SCREEN_HEIGHT,   CFG_DATA_W'(($urandom() << DIM_W) | (h & 12'hFFF)));
        write_reg(REG_ROW_PITCH,       CFG_DATA_W'(pitch));
        write_reg(REG_BYTES_PER_PIXEL, CFG_DATA_W'(($urandom() << BPP_W) | (bpp & 3'h7)));
        n_settings++;
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings: 640x480, 32-bit pixels
        draw_cmds.push_back(cmd(MODE_FLUSH, 0, 0, '0, '0, '0));          // clean flush
        draw_cmds.push_back(cmd(MODE_PIXEL, 0, 0, '0, '1, '0));
        draw_cmds.push_back(cmd(MODE_PIXEL, 639, 479, '1, '0, '1));
        draw_cmds.push_back(cmd(MODE_PIXEL, 640, 0, '1, '1, '0));         // right of screen
        draw_cmds.push_back(cmd(MODE_PIXEL, 0, 480, '1, '1, '0));         // below screen
        draw_cmds.push_back(cmd(MODE_PIXEL, 4095, 4095, '1, '1, '1));
        draw_cmds.push_back(cmd(MODE_GLYPH, 0, 10, '1, '0, 8'hA5));
        draw_cmds.push_back(cmd(MODE_GLYPH, 636, 20, 32'h00C0FFEE, '0, 8'hFF)); // clipped
        draw_cmds.push_back(cmd(MODE_GLYPH, 640, 5, '1, '1, 8'hFF));      // starts off screen
        draw_cmds.push_back(cmd(MODE_GLYPH, 10, 480, '1, '1, 8'hFF));     // row below screen
        draw_cmds.push_back(cmd(MODE_GLYPH, 100, 100, 32'h12345678, '1, 8'h00));
        draw_cmds.push_back(cmd(MODE_UNUSED, 5, 5, '1, '1, '1));
        draw_cmds.push_back(cmd(MODE_FLUSH, 0, 0, '0, '0, '0));
        draw_cmds.push_back(cmd(MODE_FLUSH, 0, 0, '0, '0, '0));          // clean again
        draw_cmds.push_back(cmd(MODE_PIXEL, 600, 400, 32'hA5A5A5A5, '0, '0));
        wait_idle();

        // shrink the screen with the box still dirty, 24-bit pixels, widest pitch
        set_screen(100, 50, 16383, BPP_NARROW);
        draw_cmds.push_back(cmd(MODE_FLUSH, 0, 0, '0, '0, '0));          // min above max
        draw_cmds.push_back(cmd(MODE_GLYPH, 96, 49, 32'hFFEEDDCC, 32'h11223344, 8'h5A));
        draw_cmds.push_back(cmd(MODE_PIXEL, 99, 49, '1, '0, '0));
        draw_cmds.push_back(cmd(MODE_FLUSH, 0, 0, '0, '0, '0));
        wait_idle();

        // oversized screen clamps to the maximum; offsets wrap at 24 bits
        set_screen(4095, 4095, 16383, 4);
        draw_cmds.push_back(cmd(MODE_PIXEL, 2047, 2047, 32'h80000001, '0, '0));
        draw_cmds.push_back(cmd(MODE_PIXEL, 2048, 0, '1, '0, '0));
        draw_cmds.push_back(cmd(MODE_GLYPH, 2044, 2047, '1, '0, 8'hC3));
        draw_cmds.push_back(cmd(MODE_FLUSH, 0, 0, '0, '0, '0));
        wait_idle();

        // zero size: nothing is on screen
        set_screen(0, 0, 1, 4);
        draw_cmds.push_back(cmd(MODE_PIXEL, 0, 0, '1, '0, '0));
        draw_cmds.push_back(cmd(MODE_GLYPH, 0, 0, '1, '0, 8'hFF));
        draw_cmds.push_back(cmd(MODE_FLUSH, 0, 0, '0, '0, '0));

        // random part, one screen setting per phase
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: set_screen(1, 1, 1, BPP_NARROW);
                1: set_screen(2048, 2048, 8192, 4);
                2: set_screen(rand_dim(), rand_dim(), $urandom_range(1, 16383), 7);
                3: set_screen(rand_dim(), rand_dim(), $urandom_range(1, 16383), 0);
                default: set_screen(rand_dim(), rand_dim(), $urandom_range(0, 16383),
                                    $urandom_range(0, 7));
            endcase
            for (int i = 0; i < PHASE_REQS; i++) draw_cmds.push_back(rand_cmd());
            if (ph == HOLD_PHASE) long_hold_req = 1'b1;
        end
        wait_idle();

        $display("covered %0d requests over %0d screen settings: %0d pixel writes, %0d flushes",
                 n_reqs, n_settings, n_writes, n_flushes);
        $display("%0d results checked, %0d mismatches", n_checked, err_count);
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
